FILE: rtl/ecsm_pkg.sv
// Types, constants and GF(23) helper functions for the scalar multiply pipeline.
`timescale 1ns / 1ps

package ecsm_pkg;

    localparam int ELEM_W   = 5;
    localparam int SCALAR_W = 5;
    localparam int PROD_W   = 10;
    localparam int FIELD_P  = 23;

    typedef logic [ELEM_W-1:0]   elem_t;
    typedef logic [SCALAR_W-1:0] scalar_t;
    typedef logic [PROD_W-1:0]   prod_t;

    typedef struct packed {
        elem_t x;
        elem_t y;
    } point_t;

    typedef enum logic [1:0] {
        MODE_CALC,
        MODE_KEEP1,
        MODE_KEEP2,
        MODE_INF
    } mode_t;

    // One point addition lane; later stages fill in more fields.
    typedef struct packed {
        mode_t  mode;
        logic   eqx;
        point_t p1;
        point_t p2;
        elem_t  sq;
        elem_t  dy;
        elem_t  dx;
        elem_t  ty;
        elem_t  num;
        elem_t  dinv;
        elem_t  slope;
        elem_t  nx;
    } lane_t;

    typedef struct packed {
        lane_t   acc;
        lane_t   dbl;
        scalar_t scalar;
    } stage_t;

    // Payload between double-and-add steps.
    typedef struct packed {
        point_t  acc;
        point_t  pt;
        scalar_t scalar;
    } step_t;

    localparam elem_t INV_TAB [0:FIELD_P-1] = '{
        5'd0,  5'd1,  5'd12, 5'd8,  5'd6,  5'd14, 5'd4,  5'd10,
        5'd3,  5'd18, 5'd7,  5'd21, 5'd2,  5'd16, 5'd5,  5'd20,
        5'd13, 5'd19, 5'd9,  5'd17, 5'd15, 5'd11, 5'd22
    };

    // Reduce a 5-bit value into 0..22.
    function automatic elem_t red5(input elem_t v);
        elem_t r;
        r = (v >= elem_t'(FIELD_P)) ? v - elem_t'(FIELD_P) : v;
        return r;
    endfunction

    // v mod 23 for v < 1024: reciprocal estimate 89/2048, then one correction.
    function automatic elem_t mod23(input prod_t v);
        logic [16:0] t;
        prod_t       q;
        prod_t       r;
        t = 17'(v) * 17'd89;
        q = prod_t'(t[16:11]);
        r = v - q * prod_t'(FIELD_P);
        if (r >= prod_t'(FIELD_P))
        begin
            r = r - prod_t'(FIELD_P);
        end
        return elem_t'(r);
    endfunction

    function automatic elem_t fsub(input elem_t u, input elem_t v);
        elem_t r;
        r = (u >= v) ? u - v : u + elem_t'(FIELD_P) - v;
        return r;
    endfunction

    function automatic elem_t fmul(input elem_t u, input elem_t v);
        return mod23(prod_t'(u) * prod_t'(v));
    endfunction

    // Stage 1: classify, x1 squared, doubled y1, differences.
    function automatic lane_t lane_s1(input point_t p1, input point_t p2, input logic en);
        lane_t           l;
        logic            inf1;
        logic            inf2;
        logic [ELEM_W:0] y2x;
        l    = '0;
        inf1 = (p1.x == '0) && (p1.y == '0);
        inf2 = (p2.x == '0) && (p2.y == '0);
        l.p1  = p1;
        l.p2  = p2;
        l.eqx = (p1.x == p2.x);
        if (!en)
        begin
            l.mode = MODE_KEEP1;
        end
        else if (inf1)
        begin
            l.mode = MODE_KEEP2;
        end
        else if (inf2)
        begin
            l.mode = MODE_KEEP1;
        end
        else if (l.eqx && ((p1.y != p2.y) || (p1.y == '0)))
        begin
            l.mode = MODE_INF;
        end
        else
        begin
            l.mode = MODE_CALC;
        end
        // 2*y1 reaches 44, so keep the carry before reducing
        y2x  = {1'b0, p1.y} + {1'b0, p1.y};
        l.ty = (y2x >= (ELEM_W+1)'(FIELD_P)) ? elem_t'(y2x - (ELEM_W+1)'(FIELD_P))
                                             : elem_t'(y2x);
        l.sq = fmul(p1.x, p1.x);
        l.dy = fsub(p2.y, p1.y);
        l.dx = fsub(p2.x, p1.x);
        return l;
    endfunction

    // Stage 2: slope numerator and inverse of the denominator.
    function automatic lane_t lane_s2(input lane_t li, input elem_t a);
        lane_t l;
        l = li;
        if (li.eqx)
        begin
            l.num  = mod23(prod_t'(li.sq) * prod_t'(3) + prod_t'(a));
            l.dinv = INV_TAB[li.ty];
        end
        else
        begin
            l.num  = li.dy;
            l.dinv = INV_TAB[li.dx];
        end
        return l;
    endfunction

    function automatic lane_t lane_s3(input lane_t li);
        lane_t l;
        l       = li;
        l.slope = fmul(li.num, li.dinv);
        return l;
    endfunction

    function automatic lane_t lane_s4(input lane_t li);
        lane_t l;
        l    = li;
        l.nx = fsub(fsub(fmul(li.slope, li.slope), li.p1.x), li.p2.x);
        return l;
    endfunction

    // Stage 5: new y from the old x1, then pick the result by case.
    function automatic point_t lane_s5(input lane_t li);
        point_t p;
        elem_t  ny;
        ny = fsub(fmul(li.slope, fsub(li.p1.x, li.nx)), li.p1.y);
        case (li.mode)
            MODE_CALC:  p = '{x: li.nx, y: ny};
            MODE_KEEP1: p = li.p1;
            MODE_KEEP2: p = li.p2;
            MODE_INF:   p = '0;
            default:    p = '0;
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/ecsm_if.sv
// Valid/ready channel interfaces: input point, result point, config write.
`timescale 1ns / 1ps

interface ecsm_in_if;
    logic               valid;
    logic               ready;
    ecsm_pkg::elem_t    point_x;
    ecsm_pkg::elem_t    point_y;
    ecsm_pkg::scalar_t  scalar;

    modport source (output valid, output point_x, output point_y, output scalar, input ready);
    modport sink   (input valid, input point_x, input point_y, input scalar, output ready);
endinterface

interface ecsm_out_if;
    logic             valid;
    logic             ready;
    ecsm_pkg::elem_t  result_x;
    ecsm_pkg::elem_t  result_y;

    modport source (output valid, output result_x, output result_y, input ready);
    modport sink   (input valid, input result_x, input result_y, output ready);
endinterface

interface ecsm_cfg_if;
    logic             valid;
    logic             ready;
    ecsm_pkg::elem_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ecsm_step.sv
// One double-and-add step: conditional add and doubling, five pipeline stages.
`timescale 1ns / 1ps

module ecsm_step (
    input  logic             clk,
    input  logic             rst_n,
    input  ecsm_pkg::elem_t  coeff_a,
    input  logic             in_valid,
    output logic             in_ready,
    input  ecsm_pkg::step_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output ecsm_pkg::step_t  out_data
);
    import ecsm_pkg::*;

    logic   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic   r1, r2, r3, r4, r5;
    stage_t s1_reg, s2_reg, s3_reg, s4_reg;
    stage_t s1_next, s2_next, s3_next, s4_next;
    step_t  s5_reg, s5_next;

    // stage advances when empty or when the next one advances
    assign r5 = !v5_reg || out_ready;
    assign r4 = !v4_reg || r5;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;

    always_comb
    begin
        s1_next.acc    = lane_s1(in_data.acc, in_data.pt, in_data.scalar[0]);
        s1_next.dbl    = lane_s1(in_data.pt, in_data.pt, 1'b1);
        s1_next.scalar = in_data.scalar >> 1;

        s2_next        = s1_reg;
        s2_next.acc    = lane_s2(s1_reg.acc, coeff_a);
        s2_next.dbl    = lane_s2(s1_reg.dbl, coeff_a);

        s3_next        = s2_reg;
        s3_next.acc    = lane_s3(s2_reg.acc);
        s3_next.dbl    = lane_s3(s2_reg.dbl);

        s4_next        = s3_reg;
        s4_next.acc    = lane_s4(s3_reg.acc);
        s4_next.dbl    = lane_s4(s3_reg.dbl);

        s5_next.acc    = lane_s5(s4_reg.acc);
        s5_next.pt     = lane_s5(s4_reg.dbl);
        s5_next.scalar = s4_reg.scalar;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= in_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
            if (r4)
            begin
                v4_reg <= v3_reg;
            end
            if (r5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            s1_reg <= s1_next;
        end
        if (r2)
        begin
            s2_reg <= s2_next;
        end
        if (r3)
        begin
            s3_reg <= s3_next;
        end
        if (r4)
        begin
            s4_reg <= s4_next;
        end
        if (r5)
        begin
            s5_reg <= s5_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = s5_reg;

endmodule

FILE: rtl/ec_point_scalar_multiply_p23.sv
// Top level: elliptic-curve scalar multiply over GF(23), LSB-first double-and-add.
`timescale 1ns / 1ps

//  channel  | role   | payload                     | transfer when
//  ---------+--------+-----------------------------+------------------------
//  pt_in    | sink   | point_x, point_y, scalar    | valid && ready
//  pt_out   | source | result_x, result_y          | valid && ready
//  cfg      | sink   | data -> curve coefficient a | valid && ready (ready=1)
//
//  One step per scalar bit, each step five stages deep (square, slope parts,
//  slope, new x, new y). One transfer per cycle is sustained while pt_out
//  is ready; the point adders are fully pipelined.
//  Reset clears only the stage valid bits and sets coefficient a to 1.
//  Stalls from pt_out back up stage by stage; bubbles are squeezed out, so
//  pt_in keeps taking items while any stage is free.

module ec_point_scalar_multiply_p23 #(
    parameter int SCALAR_BITS = 5
) (
    input  logic       clk,
    input  logic       rst_n,
    ecsm_in_if.sink    pt_in,
    ecsm_out_if.source pt_out,
    ecsm_cfg_if.sink   cfg
);
    import ecsm_pkg::*;

    // curve coefficient a, kept reduced mod 23
    elem_t coeff_a_reg;
    elem_t coeff_a_next;

    assign cfg.ready    = 1'b1;
    assign coeff_a_next = red5(cfg.data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_a_reg <= elem_t'(1);
        end
        else if (cfg.valid)
        begin
            coeff_a_reg <= coeff_a_next;
        end
    end

    // step chain: index 0 is the input, SCALAR_BITS is the final result
    logic  stg_valid [SCALAR_BITS+1];
    logic  stg_ready [SCALAR_BITS+1];
    step_t stg_data  [SCALAR_BITS+1];

    // accumulator starts at infinity; inputs are reduced mod 23 first
    assign stg_valid[0]       = pt_in.valid;
    assign pt_in.ready        = stg_ready[0];
    assign stg_data[0].acc    = '0;
    assign stg_data[0].pt.x   = red5(pt_in.point_x);
    assign stg_data[0].pt.y   = red5(pt_in.point_y);
    assign stg_data[0].scalar = pt_in.scalar;

    for (genvar i = 0; i < SCALAR_BITS; i++)
    begin : g_step
        ecsm_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .coeff_a   (coeff_a_reg),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    assign pt_out.valid             = stg_valid[SCALAR_BITS];
    assign stg_ready[SCALAR_BITS]   = pt_out.ready;
    assign pt_out.result_x          = stg_data[SCALAR_BITS].acc.x;
    assign pt_out.result_y          = stg_data[SCALAR_BITS].acc.y;

    // every field element leaving the pipe is reduced
    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        pt_out.valid |-> (pt_out.result_x < elem_t'(FIELD_P))
                      && (pt_out.result_y < elem_t'(FIELD_P)))
        else $error("result coordinate not reduced mod 23");

    // a config write lands reduced in the coefficient register
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready) |=> (coeff_a_reg == $past(coeff_a_next)))
        else $error("coefficient register missed a config write");

    a_coeff_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        coeff_a_reg < elem_t'(FIELD_P))
        else $error("coefficient a out of range");

    // a stalled result must not change under the consumer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pt_out.valid && !pt_out.ready) |=>
            (pt_out.valid && $stable(pt_out.result_x) && $stable(pt_out.result_y)))
        else $error("stalled result changed");

endmodule
